### design/pwfd_pkg.sv
package pwfd_pkg;

  // Byte slots in one frame; the byte count saturates at the last slot.
  localparam int PayloadMax = 64;
  localparam int ByteCntW   = 6;
  localparam int BitsPerByte = 8;

  // Window register indexes on the configuration port.
  localparam int NumRegs = 7;
  localparam logic [2:0] RegSyncLow  = 3'd0;
  localparam logic [2:0] RegSyncHigh = 3'd1;
  localparam logic [2:0] RegOneLow   = 3'd2;
  localparam logic [2:0] RegZeroLow  = 3'd3;
  localparam logic [2:0] RegStopLow  = 3'd4;
  localparam logic [2:0] RegOneHigh  = 3'd5;
  localparam logic [2:0] RegZeroHigh = 3'd6;

  // Kind of a result word.
  typedef enum logic [1:0] {
    EvByte  = 2'd0,
    EvEnd   = 2'd1,
    EvError = 2'd2
  } event_kind_e;

  // One line sample.
  typedef struct packed {
    logic        line_level;
    logic [31:0] sample_time;
  } in_word_t;

  // One decoder event.
  typedef struct packed {
    event_kind_e          event_kind;
    logic [7:0]           byte_value;
    logic [ByteCntW-1:0]  byte_index;
    logic [ByteCntW-1:0]  frame_length;
    logic [31:0]          frames_seen;
    logic [31:0]          errors_seen;
  } out_word_t;

  // A window holds the inclusive minimum in its low half and the maximum in its high half.
  function automatic logic in_window(input logic [31:0] win, input logic [31:0] width);
    in_window = (width >= {16'h0000, win[15:0]}) && (width <= {16'h0000, win[31:16]});
  endfunction

  // True when the width is above the window maximum.
  function automatic logic above_window(input logic [31:0] win, input logic [31:0] width);
    above_window = width > {16'h0000, win[31:16]};
  endfunction

endpackage

### design/pulse_width_frame_decoder.sv
// An edge sample that causes an event shows it on the output in the cycle after acceptance.
// Throughput: one sample per cycle while no result waits untaken; the single output register
// is refilled in the cycle it is taken. Each sample is handled by one 32-bit subtract and a
// few 32-bit window compares. Reset (rst_ni low, asynchronous): decoder idle, line assumed
// high, counters and windows cleared, no output word pending.
module pulse_width_frame_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pwfd_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pwfd_pkg::out_word_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhSyncLow  = 3'd1,
    PhSyncHigh = 3'd2,
    PhBitLow   = 3'd3,
    PhBitHigh  = 3'd4
  } phase_e;

  logic [31:0] win_q [pwfd_pkg::NumRegs];

  phase_e                        phase_q, phase_d;
  logic                          prior_level_q, prior_level_d;
  logic [31:0]                   prior_time_q, prior_time_d;
  logic                          pending_bit_q, pending_bit_d;
  logic [2:0]                    bit_pos_q, bit_pos_d;
  logic [7:0]                    byte_shift_q, byte_shift_d;
  logic [pwfd_pkg::ByteCntW-1:0] byte_total_q, byte_total_d;
  logic [31:0]                   frame_cnt_q, frame_cnt_d;
  logic [31:0]                   error_cnt_q, error_cnt_d;

  logic                 out_valid_q;
  pwfd_pkg::out_word_t  out_data_q, result;
  logic                 emit;

  logic        in_fire, out_fire, is_edge, rising;
  logic [31:0] width;

  assign out_fire    = out_valid_q && out_ready_i;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign is_edge = in_data_i.line_level != prior_level_q;
  assign rising  = in_data_i.line_level;
  assign width   = in_data_i.sample_time - prior_time_q;

  // Window registers, written from the configuration port; other indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pwfd_pkg::NumRegs; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_index_i < 3'(pwfd_pkg::NumRegs))) begin
      win_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Next decoder state and the event, if any, for the sample on the input.
  always_comb begin
    phase_d        = phase_q;
    prior_level_d  = prior_level_q;
    prior_time_d   = prior_time_q;
    pending_bit_d  = pending_bit_q;
    bit_pos_d      = bit_pos_q;
    byte_shift_d   = byte_shift_q;
    byte_total_d   = byte_total_q;
    frame_cnt_d    = frame_cnt_q;
    error_cnt_d    = error_cnt_q;
    emit           = 1'b0;
    result.event_kind   = pwfd_pkg::EvByte;
    result.byte_value   = '0;
    result.byte_index   = '0;
    result.frame_length = '0;

    if (is_edge) begin
      prior_level_d = in_data_i.line_level;
      prior_time_d  = in_data_i.sample_time;
      case (phase_q)
        PhSyncLow: begin
          if (rising) begin
            phase_d = pwfd_pkg::in_window(win_q[pwfd_pkg::RegSyncLow], width) ?
                      PhSyncHigh : PhIdle;
          end
        end
        PhSyncHigh: begin
          if (!rising) begin
            if (pwfd_pkg::in_window(win_q[pwfd_pkg::RegSyncHigh], width)) begin
              phase_d      = PhBitLow;
              frame_cnt_d  = frame_cnt_q + 32'd1;
              byte_total_d = '0;
              bit_pos_d    = '0;
            end else begin
              phase_d = PhIdle;
            end
          end
        end
        PhBitLow: begin
          if (rising) begin
            if (pwfd_pkg::in_window(win_q[pwfd_pkg::RegOneLow], width)) begin
              pending_bit_d = 1'b1;
              phase_d       = PhBitHigh;
            end else if (pwfd_pkg::in_window(win_q[pwfd_pkg::RegZeroLow], width)) begin
              pending_bit_d = 1'b0;
              phase_d       = PhBitHigh;
            end else if (pwfd_pkg::in_window(win_q[pwfd_pkg::RegStopLow], width) ||
                         pwfd_pkg::above_window(win_q[pwfd_pkg::RegStopLow], width)) begin
              // A stop with no byte received is ignored.
              if (byte_total_q != '0) begin
                phase_d             = PhIdle;
                emit                = 1'b1;
                result.event_kind   = pwfd_pkg::EvEnd;
                result.frame_length = byte_total_q;
              end
            end else begin
              phase_d           = PhIdle;
              error_cnt_d       = error_cnt_q + 32'd1;
              emit              = 1'b1;
              result.event_kind = pwfd_pkg::EvError;
            end
          end
        end
        PhBitHigh: begin
          if (!rising) begin
            if (!pwfd_pkg::in_window(pending_bit_q ? win_q[pwfd_pkg::RegOneHigh] :
                                     win_q[pwfd_pkg::RegZeroHigh], width)) begin
              phase_d           = PhIdle;
              error_cnt_d       = error_cnt_q + 32'd1;
              emit              = 1'b1;
              result.event_kind = pwfd_pkg::EvError;
            end else begin
              byte_shift_d[bit_pos_q] = pending_bit_q;
              phase_d   = PhBitLow;
              bit_pos_d = bit_pos_q + 3'd1;
              // The last bit of a byte completes it; the slot count saturates.
              if (bit_pos_q == 3'(pwfd_pkg::BitsPerByte - 1)) begin
                if (byte_total_q != pwfd_pkg::ByteCntW'(pwfd_pkg::PayloadMax - 1)) begin
                  byte_total_d = byte_total_q + pwfd_pkg::ByteCntW'(1);
                end
                emit              = 1'b1;
                result.event_kind = pwfd_pkg::EvByte;
                result.byte_value = byte_shift_d;
                result.byte_index = byte_total_q;
              end
            end
          end
        end
        default: begin
          phase_d = rising ? PhIdle : PhSyncLow;
        end
      endcase
    end
    result.frames_seen = frame_cnt_d;
    result.errors_seen = error_cnt_d;
  end

  // Decoder state, updated on every accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      prior_level_q <= 1'b1;
      prior_time_q  <= '0;
      pending_bit_q <= 1'b0;
      bit_pos_q     <= '0;
      byte_shift_q  <= '0;
      byte_total_q  <= '0;
      frame_cnt_q   <= '0;
      error_cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      prior_level_q <= prior_level_d;
      prior_time_q  <= prior_time_d;
      pending_bit_q <= pending_bit_d;
      bit_pos_q     <= bit_pos_d;
      byte_shift_q  <= byte_shift_d;
      byte_total_q  <= byte_total_d;
      frame_cnt_q   <= frame_cnt_d;
      error_cnt_q   <= error_cnt_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_data_q <= result;
    end
  end

endmodule

### design/pwfd_checker.sv
module pwfd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input pwfd_pkg::out_word_t  out_data_o
);

  // A pending word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // The decoder only stalls input while a result waits and is not being taken.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A new word appears only after a sample was accepted.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result word without an accepted sample");

  // Only byte events carry a byte value and index; only end events carry a length.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.event_kind == pwfd_pkg::EvByte && out_data_o.frame_length == '0) ||
      (out_data_o.event_kind == pwfd_pkg::EvEnd && out_data_o.byte_value == '0 &&
       out_data_o.byte_index == '0 && out_data_o.frame_length != '0) ||
      (out_data_o.event_kind == pwfd_pkg::EvError && out_data_o.byte_value == '0 &&
       out_data_o.byte_index == '0 && out_data_o.frame_length == '0))
    else $error("result word fields do not fit its kind");

endmodule

bind pulse_width_frame_decoder pwfd_checker u_pwfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
